@@ rtl/dpa_pkg.sv @@
// descriptor pool allocator: shared types, codes and widths
// used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package dpa_pkg;

  localparam int unsigned HANDLE_W     = 6;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned HANDLE_LIMIT = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_WALK    = 2'd2
  } dpa_cmd_e;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNALLOC   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic alloc_do;
    logic alloc_fail;
    logic rel_fail;
    logic rel_unlink;
    logic rel_push;
    logic walk_empty;
    logic walk_step;
  } dpa_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             alloc_ok;
    logic             rel_ok;
    logic             used_valid;
    logic             walk_more;
    logic             out_free;
  } dpa_sts_t;

endpackage

`default_nettype wire

@@ rtl/dpa_if.sv @@
// descriptor pool allocator: valid/ready channel interfaces
// depends on dpa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpa_pkg::CMD_W-1:0]     cmd;
  logic [dpa_pkg::HANDLE_W-1:0]  handle_in;
  modport source (output valid, output cmd, output handle_in, input ready);
  modport sink (input valid, input cmd, input handle_in, output ready);
endinterface

interface dpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [dpa_pkg::HANDLE_W-1:0]  handle_out;
  logic [dpa_pkg::STATUS_W-1:0]  status;
  logic                          last;
  modport source (output valid, output handle_out, output status, output last, input ready);
  modport sink (input valid, input handle_out, input status, input last, output ready);
endinterface

interface dpa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dpa_pkg::CNT_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/dpa_ctrl.sv @@
// descriptor pool allocator: command sequencer
// depends on dpa_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module dpa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [dpa_pkg::CMD_W-1:0] in_cmd_i,
  output logic                      in_ready_o,
  input  dpa_pkg::dpa_sts_t         sts_i,
  output dpa_pkg::dpa_ctl_t         ctl_o
);
  import dpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_PUSH = 4'b0100,
    S_WALK = 4'b1000
  } dpa_state_e;

  dpa_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    ctl_o.accept = in_valid_i && in_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (ctl_o.accept && (in_cmd_i == CMD_ALLOC || in_cmd_i == CMD_RELEASE ||
                             in_cmd_i == CMD_WALK)) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts_i.cmd == CMD_RELEASE && sts_i.rel_ok) begin
          ctl_o.rel_unlink = 1'b1;
          state_d          = S_PUSH;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
          priority if (sts_i.cmd == CMD_ALLOC) begin
            ctl_o.alloc_do   = sts_i.alloc_ok;
            ctl_o.alloc_fail = !sts_i.alloc_ok;
          end else if (sts_i.cmd == CMD_RELEASE) begin
            ctl_o.rel_fail = 1'b1;
          end else if (sts_i.cmd == CMD_WALK) begin
            if (!sts_i.used_valid) begin
              ctl_o.walk_empty = 1'b1;
            end else begin
              ctl_o.walk_step = 1'b1;
              if (sts_i.walk_more) begin
                state_d = S_WALK;
              end
            end
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_EXEC;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          ctl_o.rel_push = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          ctl_o.walk_step = 1'b1;
          if (!sts_i.walk_more) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dpa_datapath.sv @@
// descriptor pool allocator: link memories, list heads, flags and result register
// depends on dpa_pkg; driven by dpa_ctrl through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module dpa_datapath #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dpa_pkg::CMD_W-1:0]    in_cmd_i,
  input  logic [dpa_pkg::HANDLE_W-1:0] in_handle_i,
  input  logic                         cfg_we_i,
  input  logic [dpa_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [dpa_pkg::HANDLE_W-1:0] out_handle_o,
  output logic [dpa_pkg::STATUS_W-1:0] out_status_o,
  output logic                         out_last_o,
  input  dpa_pkg::dpa_ctl_t            ctl_i,
  output dpa_pkg::dpa_sts_t            sts_o
);
  import dpa_pkg::*;

  localparam int unsigned SLOT_DEPTH = (POOL_SLOTS < HANDLE_LIMIT) ? POOL_SLOTS : HANDLE_LIMIT;
  localparam int unsigned AW         = $clog2(SLOT_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SLOT_DEPTH);

  // next word: {link valid, link}
  logic [AW:0]   next_mem [SLOT_DEPTH];
  logic [AW-1:0] prev_mem [SLOT_DEPTH];
  logic [AW:0]   next_rd_q;
  logic [AW-1:0] prev_rd_q;

  logic [AW-1:0]         free_head_q, used_head_q, cur_q;
  logic                  free_valid_q, used_valid_q;
  logic [CNT_W-1:0]      created_q, max_q, limit;
  logic [SLOT_DEPTH-1:0] alloc_flags_q;
  logic [CMD_W-1:0]      cmd_q;
  logic [HANDLE_W-1:0]   hin_q;
  logic [AW-1:0]         hin_idx, h_new;
  logic                  in_range, is_head, emit;

  logic          next_we, next_re, prev_we;
  logic [AW-1:0] next_wa, next_ra, prev_wa;
  logic [AW:0]   next_wd;
  logic [AW-1:0] prev_wd;

  logic                out_valid_q;
  logic [HANDLE_W-1:0] out_handle_d;
  logic [STATUS_W-1:0] out_status_d;
  logic                out_last_d;

  assign hin_idx  = hin_q[AW-1:0];
  assign in_range = (int'(hin_q) < POOL_SLOTS);
  assign is_head  = used_valid_q && (used_head_q == hin_idx);
  assign h_new    = free_valid_q ? free_head_q : created_q[AW-1:0];
  assign limit    = (max_q > DEPTH_CNT) ? DEPTH_CNT : max_q;

  assign sts_o.cmd        = cmd_q;
  assign sts_o.alloc_ok   = free_valid_q || (created_q < limit);
  assign sts_o.rel_ok     = in_range && alloc_flags_q[hin_idx];
  assign sts_o.used_valid = used_valid_q;
  assign sts_o.walk_more  = next_rd_q[AW];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign emit = ctl_i.alloc_do || ctl_i.alloc_fail || ctl_i.rel_fail || ctl_i.rel_push ||
                ctl_i.walk_empty || ctl_i.walk_step;

  // read address: list head or released handle chosen by the incoming command, else the walk pointer
  always_comb begin
    next_re = ctl_i.accept || (ctl_i.walk_step && next_rd_q[AW]);
    priority if (!ctl_i.accept) begin
      next_ra = next_rd_q[AW-1:0];
    end else if (in_cmd_i == CMD_ALLOC) begin
      next_ra = free_head_q;
    end else if (in_cmd_i == CMD_RELEASE) begin
      next_ra = in_handle_i[AW-1:0];
    end else begin
      next_ra = used_head_q;
    end
  end

  always_comb begin
    next_we = 1'b0;
    next_wa = hin_idx;
    next_wd = {free_valid_q, free_head_q};
    prev_we = 1'b0;
    prev_wa = used_head_q;
    prev_wd = h_new;
    priority if (ctl_i.alloc_do) begin
      next_we = 1'b1;
      next_wa = h_new;
      next_wd = {used_valid_q, used_head_q};
      prev_we = used_valid_q;
    end else if (ctl_i.rel_unlink) begin
      // bypass the handle: predecessor takes its successor
      next_we = !is_head;
      next_wa = prev_rd_q;
      next_wd = next_rd_q;
      prev_we = !is_head && next_rd_q[AW];
      prev_wa = next_rd_q[AW-1:0];
      prev_wd = prev_rd_q;
    end else if (ctl_i.rel_push) begin
      next_we = 1'b1;
    end else begin
      next_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (next_re) begin
      next_rd_q <= next_mem[next_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (ctl_i.accept) begin
      prev_rd_q <= prev_mem[in_handle_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q   <= '0;
      free_valid_q  <= 1'b0;
      used_head_q   <= '0;
      used_valid_q  <= 1'b0;
      created_q     <= '0;
      max_q         <= CNT_W'(HANDLE_LIMIT);
      alloc_flags_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (ctl_i.alloc_do) begin
        if (free_valid_q) begin
          free_head_q  <= next_rd_q[AW-1:0];
          free_valid_q <= next_rd_q[AW];
        end else begin
          created_q <= created_q + CNT_W'(1);
        end
        used_head_q            <= h_new;
        used_valid_q           <= 1'b1;
        alloc_flags_q[h_new]   <= 1'b1;
      end
      if (ctl_i.rel_unlink && is_head) begin
        used_head_q  <= next_rd_q[AW-1:0];
        used_valid_q <= next_rd_q[AW];
      end
      if (ctl_i.rel_push) begin
        free_head_q            <= hin_idx;
        free_valid_q           <= 1'b1;
        alloc_flags_q[hin_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q <= in_cmd_i;
      hin_q <= in_handle_i;
      cur_q <= used_head_q;
    end else if (ctl_i.walk_step) begin
      cur_q <= next_rd_q[AW-1:0];
    end
  end

  // result register
  always_comb begin
    out_handle_d = HANDLE_W'(cur_q);
    out_status_d = STAT_OK;
    out_last_d   = !next_rd_q[AW];
    priority if (ctl_i.alloc_do) begin
      out_handle_d = HANDLE_W'(h_new);
      out_last_d   = 1'b1;
    end else if (ctl_i.alloc_fail) begin
      out_handle_d = '0;
      out_status_d = STAT_EXHAUSTED;
      out_last_d   = 1'b1;
    end else if (ctl_i.rel_fail) begin
      out_handle_d = hin_q;
      out_status_d = STAT_UNALLOC;
      out_last_d   = 1'b1;
    end else if (ctl_i.rel_push) begin
      out_handle_d = hin_q;
      out_last_d   = 1'b1;
    end else if (ctl_i.walk_empty) begin
      out_handle_d = '0;
      out_status_d = STAT_EMPTY;
      out_last_d   = 1'b1;
    end else begin
      out_last_d = !next_rd_q[AW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_handle_o <= out_handle_d;
      out_status_o <= out_status_d;
      out_last_o   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.walk_step |-> used_valid_q)
    else $error("walk step on empty in-use list");

  a_alloc_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc_do |-> !alloc_flags_q[h_new])
    else $error("handle allocated twice");

  a_created_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc_do && !free_valid_q |=> created_q <= DEPTH_CNT)
    else $error("created count beyond pool depth");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.rel_push |=> free_valid_q && !used_valid_q || free_valid_q)
    else $error("free list empty after release");
`endif

endmodule

`default_nettype wire

@@ rtl/descriptor_pool_allocator.sv @@
// descriptor pool allocator: top level joining controller and datapath
// depends on dpa_pkg, dpa_if, dpa_ctrl and dpa_datapath
//
// usage: handles 0..min(POOL_SLOTS,64)-1 are handed out from a pool
//  in_i   command transfer: cmd (allocate, release handle_in, walk) and handle_in
//  out_o  result transfers: handle_out, status and last, one per allocate or release,
//         one per in-use handle for a walk (head first), last set on the final one
//  cfg_i  writes max_elements, taken in every cycle, meant only while idle
// sequence: one command at a time; an allocate passes the execute state and then
//  the result register, a release the execute state, the push state and then the
//  result register; a walk gives its first handle from the execute state, then
//  one handle per cycle while the receiver does not stall, paced by the registered
//  read of the next-link memory along the in-use list; a command of code 3 is taken
//  and produces nothing, and the sequencer stays in idle
// a new command is taken as soon as the sequencer is back in idle, even while the
//  last result still waits in the output register; a stalled receiver holds the
//  result register and the sequencer, nothing is dropped
// reset: both lists empty, no handle created, max_elements = 64; link memories
//  are not cleared and need no sweep, so commands are taken right after reset
`timescale 1ns / 1ps
`default_nettype none

module descriptor_pool_allocator #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  dpa_in_if.sink    in_i,
  dpa_out_if.source out_o,
  dpa_cfg_if.sink   cfg_i
);
  import dpa_pkg::*;

  dpa_ctl_t ctl;
  dpa_sts_t sts;

  assign cfg_i.ready = 1'b1;

  dpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  dpa_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (in_i.cmd),
    .in_handle_i  (in_i.handle_in),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_handle_o (out_o.handle_out),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last),
    .ctl_i        (ctl),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire
